/* design/sbnr_pkg.sv */
// Shared types, constants and direction tables for the small blob noise removal core.
package sbnr_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_MAX_RUN    = 25;

   localparam int CSR_DATA_W  = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int NUM_DIRS    = 8;

   localparam logic [7:0] WHITE = 8'd255;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_MIN_SIZE     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_DIV,
      TOP_WALK,
      TOP_HOLD
   } top_state_type;

   typedef enum logic [3:0] {
      W_INIT,
      W_IDLE,
      W_SADDR,
      W_SREAD,
      W_NEXT,
      W_ADDR,
      W_CHECK,
      W_CLEAR,
      W_DONE
   } walk_state_type;

   typedef struct packed {
      logic       ready;
      logic       done;
      logic       keep;
      logic [7:0] start_pixel;
   } walk_status_type;

   // Neighbor order: up, up-left, left, down-left, down, down-right, right, up-right.
   function automatic logic signed [1:0] step_dx(input logic [2:0] dir);
      logic signed [1:0] r;
      case (dir)
         3'd1, 3'd2, 3'd3: r = -2'sd1;
         3'd5, 3'd6, 3'd7: r = 2'sd1;
         default:          r = 2'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [1:0] step_dy(input logic [2:0] dir);
      logic signed [1:0] r;
      case (dir)
         3'd0, 3'd1, 3'd7: r = -2'sd1;
         3'd3, 3'd4, 3'd5: r = 2'sd1;
         default:          r = 2'sd0;
      endcase
      return r;
   endfunction

endpackage

/* design/sbnr_divider.sv */
// Restoring divider, one quotient bit per cycle: splits a raster index into row and column.
module sbnr_divider #(
   parameter int MAX_WIDTH  = sbnr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sbnr_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] dividend,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]         divisor,
   output logic                                   done,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] quotient,
   output logic [$clog2(MAX_WIDTH+1)-1:0]         remainder
);
   localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH+1);
   localparam int CW = $clog2(AW+1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [AW-1:0] num_ff;
   logic [AW-1:0] quo_ff;
   logic [WW-1:0] rem_ff;
   logic [WW:0]   trial;
   logic          fits;

   assign trial = {rem_ff, num_ff[AW-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(AW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[AW-2:0], 1'b0};
         quo_ff <= {quo_ff[AW-2:0], fits};
         rem_ff <= fits ? WW'(trial - {1'b0, divisor}) : WW'(trial);
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

/* design/sbnr_walker.sv */
// Depth-first group walker: stack, visit list, visit marks and the shared address unit.
module sbnr_walker #(
   parameter int MAX_WIDTH  = sbnr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sbnr_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RUN    = sbnr_pkg::DEF_MAX_RUN
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [$clog2(MAX_WIDTH)-1:0]           start_x,
   input  logic [$clog2(MAX_HEIGHT)-1:0]          start_y,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]         width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]        height,
   input  logic [$clog2(MAX_RUN+1)-1:0]           need,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] pix_rd_addr,
   input  logic [7:0]                             pix_rd_data,
   output sbnr_pkg::walk_status_type              status
);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH+1);
   localparam int HW    = $clog2(MAX_HEIGHT+1);
   localparam int DEPTH = MAX_WIDTH*MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(MAX_RUN+1);
   localparam int SW    = $clog2(MAX_RUN);
   localparam int PW    = WW+HW;

   sbnr_pkg::walk_state_type state_ff, state_in;

   logic [XW-1:0] stk_x_ff   [MAX_RUN];
   logic [YW-1:0] stk_y_ff   [MAX_RUN];
   logic [3:0]    stk_dir_ff [MAX_RUN];
   logic [AW-1:0] list_ff    [MAX_RUN];
   logic [NW-1:0] depth_ff;
   logic [NW-1:0] count_ff;
   logic [NW-1:0] clr_ff;
   logic [AW-1:0] init_ff;
   logic [XW-1:0] nb_x_ff;
   logic [YW-1:0] nb_y_ff;
   logic [AW-1:0] nb_pos_ff;
   logic          keep_ff;
   logic [7:0]    start_pix_ff;

   logic          vis_mem [DEPTH];
   logic          vis_rd_ff;
   logic          vis_we;
   logic [AW-1:0] vis_wa;
   logic          vis_wd;

   logic [NW-1:0]       depth_m1;
   logic [SW-1:0]       top_idx;
   logic [XW-1:0]       tx;
   logic [YW-1:0]       ty;
   logic [3:0]          tdir;
   logic signed [XW+1:0] nx_s;
   logic signed [YW+1:0] ny_s;
   logic                in_x, in_y;
   logic [XW-1:0]       mul_x;
   logic [YW-1:0]       mul_y;
   logic [PW-1:0]       prod;
   logic [AW-1:0]       mpos;
   logic                hit;
   logic [NW-1:0]       count_p1;

   assign depth_m1 = depth_ff - NW'(1);
   assign top_idx  = depth_m1[SW-1:0];
   assign tx       = stk_x_ff[top_idx];
   assign ty       = stk_y_ff[top_idx];
   assign tdir     = stk_dir_ff[top_idx];

   // Neighbor coordinate and bounds check against the image in use.
   assign nx_s = $signed({2'b00, tx}) + (XW+2)'(sbnr_pkg::step_dx(tdir[2:0]));
   assign ny_s = $signed({2'b00, ty}) + (YW+2)'(sbnr_pkg::step_dy(tdir[2:0]));
   assign in_x = !nx_s[XW+1] && ({1'b0, nx_s[XW:0]} < (XW+2)'(width));
   assign in_y = !ny_s[YW+1] && ({1'b0, ny_s[YW:0]} < (YW+2)'(height));

   // Shared address unit: row times width plus column.
   assign mul_x = (state_ff == sbnr_pkg::W_IDLE) ? start_x : nx_s[XW-1:0];
   assign mul_y = (state_ff == sbnr_pkg::W_IDLE) ? start_y : ny_s[YW-1:0];
   assign prod  = PW'(mul_y) * PW'(width);
   assign mpos  = AW'(prod + PW'(mul_x));

   assign hit      = (pix_rd_data == 8'd0) && !vis_rd_ff;
   assign count_p1 = count_ff + NW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbnr_pkg::W_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      vis_we   = 1'b0;
      vis_wa   = nb_pos_ff;
      vis_wd   = 1'b1;
      case (state_ff)
         sbnr_pkg::W_INIT: begin
            vis_we = 1'b1;
            vis_wa = init_ff;
            vis_wd = 1'b0;
            if (init_ff == AW'(DEPTH-1)) state_in = sbnr_pkg::W_IDLE;
         end
         sbnr_pkg::W_IDLE: begin
            if (start) state_in = sbnr_pkg::W_SADDR;
         end
         sbnr_pkg::W_SADDR: state_in = sbnr_pkg::W_SREAD;
         sbnr_pkg::W_SREAD: begin
            if (need == '0 || need == NW'(1)) begin
               state_in = sbnr_pkg::W_CLEAR;
            end else begin
               state_in = sbnr_pkg::W_NEXT;
            end
            vis_we = (need != '0);
         end
         sbnr_pkg::W_NEXT: begin
            if (depth_ff == '0) begin
               state_in = sbnr_pkg::W_CLEAR;
            end else if (tdir != 4'(sbnr_pkg::NUM_DIRS) && in_x && in_y) begin
               state_in = sbnr_pkg::W_ADDR;
            end
         end
         sbnr_pkg::W_ADDR: state_in = sbnr_pkg::W_CHECK;
         sbnr_pkg::W_CHECK: begin
            vis_we = hit;
            if (hit && count_p1 >= need) begin
               state_in = sbnr_pkg::W_CLEAR;
            end else begin
               state_in = sbnr_pkg::W_NEXT;
            end
         end
         sbnr_pkg::W_CLEAR: begin
            if (clr_ff < count_ff) begin
               vis_we = 1'b1;
               vis_wa = list_ff[clr_ff[SW-1:0]];
               vis_wd = 1'b0;
            end else begin
               state_in = sbnr_pkg::W_DONE;
            end
         end
         sbnr_pkg::W_DONE: state_in = sbnr_pkg::W_IDLE;
         default: state_in = sbnr_pkg::W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= '0;
      end else if (state_ff == sbnr_pkg::W_INIT) begin
         init_ff <= init_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         sbnr_pkg::W_IDLE: begin
            nb_x_ff   <= start_x;
            nb_y_ff   <= start_y;
            nb_pos_ff <= mpos;
            count_ff  <= '0;
            depth_ff  <= '0;
            clr_ff    <= '0;
         end
         sbnr_pkg::W_SREAD: begin
            start_pix_ff <= pix_rd_data;
            if (need == '0) begin
               keep_ff <= 1'b1;
            end else begin
               list_ff[0]    <= nb_pos_ff;
               count_ff      <= NW'(1);
               keep_ff       <= (need == NW'(1));
               stk_x_ff[0]   <= nb_x_ff;
               stk_y_ff[0]   <= nb_y_ff;
               stk_dir_ff[0] <= 4'd0;
               depth_ff      <= NW'(1);
            end
         end
         sbnr_pkg::W_NEXT: begin
            if (depth_ff != '0) begin
               if (tdir == 4'(sbnr_pkg::NUM_DIRS)) begin
                  depth_ff <= depth_m1;
               end else begin
                  stk_dir_ff[top_idx] <= tdir + 4'd1;
                  nb_x_ff   <= nx_s[XW-1:0];
                  nb_y_ff   <= ny_s[YW-1:0];
                  nb_pos_ff <= mpos;
               end
            end
         end
         sbnr_pkg::W_CHECK: begin
            if (hit) begin
               list_ff[count_ff[SW-1:0]] <= nb_pos_ff;
               count_ff <= count_p1;
               if (count_p1 >= need) begin
                  keep_ff <= 1'b1;
               end else if (depth_ff < NW'(MAX_RUN)) begin
                  stk_x_ff[depth_ff[SW-1:0]]   <= nb_x_ff;
                  stk_y_ff[depth_ff[SW-1:0]]   <= nb_y_ff;
                  stk_dir_ff[depth_ff[SW-1:0]] <= 4'd0;
                  depth_ff <= depth_ff + NW'(1);
               end
            end
         end
         sbnr_pkg::W_CLEAR: begin
            if (clr_ff < count_ff) clr_ff <= clr_ff + NW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_wa] <= vis_wd;
      vis_rd_ff <= vis_mem[nb_pos_ff];
   end

   assign pix_rd_addr        = nb_pos_ff;
   assign status.ready       = (state_ff == sbnr_pkg::W_IDLE);
   assign status.done        = (state_ff == sbnr_pkg::W_DONE);
   assign status.keep        = keep_ff;
   assign status.start_pixel = start_pix_ff;

endmodule

/* design/small_blob_noise_removal_core.sv */
// Top level: pixel store, registers, raster indexes and query sequencer of the blob cleaner.
//
//  channel  ports                                direction  handshake
//  req      command, pixel_value                 in         req_valid / req_ready
//  rsp      cleaned_pixel, was_noise, last_pixel out        rsp_valid / rsp_ready
//  csr      index, write_data                    in         csr_write_enable, no wait
//
// A load beat writes the store directly. A query splits row and column in the divider,
// reads and marks the start pixel, then per neighbor skips it if out of image or reads and
// checks it, pops spent stack entries, clears the visit marks, finishes, fills the output reg.
// After reset, sweep the visit marks to zero one per cycle with req_ready low; register
// writes are taken then. A held result stalls only the next query's end. req_ready drops
// for one cycle after a register write.
module small_blob_noise_removal_core #(
   parameter int MAX_WIDTH  = sbnr_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = sbnr_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_RUN    = sbnr_pkg::DEF_MAX_RUN
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [7:0]                       req_pixel_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_cleaned_pixel,
   output logic                             rsp_was_noise,
   output logic                             rsp_last_pixel,
   input  logic                             csr_write_enable,
   input  logic [sbnr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sbnr_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH+1);
   localparam int HW    = $clog2(MAX_HEIGHT+1);
   localparam int DEPTH = MAX_WIDTH*MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = $clog2(MAX_RUN+1);
   localparam int PW    = WW+HW;

   sbnr_pkg::top_state_type state_ff, state_in;

   // Configuration registers.
   logic [8:0] width_ff;
   logic [8:0] height_ff;
   logic [4:0] min_size_ff;
   logic       settled_ff;

   // Effective sizes, saturated to the store; the group size is saturated to MAX_RUN.
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [NW-1:0] need;
   logic [AW:0]   total_ff;

   logic [AW-1:0] load_index_ff;
   logic [AW-1:0] read_index_ff;
   logic [AW-1:0] lidx, qidx;
   logic [AW:0]   lnext, qnext;
   logic          last_ff;

   logic [7:0]    pix_mem [DEPTH];
   logic [7:0]    pix_rd_ff;
   logic [AW-1:0] pix_rd_addr;

   logic          req_fire, rsp_fire, rsp_load;
   logic          div_start, div_done;
   logic [AW-1:0] div_quo;
   logic [WW-1:0] div_rem;
   logic          walk_start;

   sbnr_pkg::walk_status_type walk_sts;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_pixel_ff;
   logic          rsp_noise_ff;
   logic          rsp_last_ff;

   // Register writes: clip to each register's width, drop unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 9'd200;
         height_ff   <= 9'd200;
         min_size_ff <= 5'd8;
         settled_ff  <= 1'b0;
      end else begin
         settled_ff <= !csr_write_enable;
         if (csr_write_enable) begin
            case (csr_index)
               sbnr_pkg::CSR_IMAGE_WIDTH:  width_ff    <= csr_write_data;
               sbnr_pkg::CSR_IMAGE_HEIGHT: height_ff   <= csr_write_data;
               sbnr_pkg::CSR_MIN_SIZE:     min_size_ff <= csr_write_data[4:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      if (width_ff == 9'd0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff == 9'd0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
      if (32'(min_size_ff) > MAX_RUN) begin
         need = NW'(MAX_RUN);
      end else begin
         need = NW'(min_size_ff);
      end
   end

   // Pixel count of the image in use; registered, so it settles after the size registers.
   always_ff @(posedge clock) begin
      total_ff <= (AW+1)'(PW'(w_eff) * PW'(h_eff));
   end

   assign req_ready = (state_ff == sbnr_pkg::TOP_IDLE) && walk_sts.ready && settled_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign rsp_load  = (state_ff == sbnr_pkg::TOP_HOLD) && (!rsp_valid_ff || rsp_ready);

   // Restart an index that fell outside the image, wrap after the last pixel.
   assign lidx  = ({1'b0, load_index_ff} >= total_ff) ? '0 : load_index_ff;
   assign qidx  = ({1'b0, read_index_ff} >= total_ff) ? '0 : read_index_ff;
   assign lnext = {1'b0, lidx} + (AW+1)'(1);
   assign qnext = {1'b0, qidx} + (AW+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
         read_index_ff <= '0;
      end else if (req_fire) begin
         if (req_command == sbnr_pkg::CMD_LOAD) begin
            load_index_ff <= (lnext >= total_ff) ? '0 : lnext[AW-1:0];
         end else begin
            read_index_ff <= (qnext >= total_ff) ? '0 : qnext[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_command == sbnr_pkg::CMD_QUERY) begin
         last_ff <= (qnext == total_ff);
      end
   end

   // Pixel store: written by loads, read by the walker through a registered read port.
   always_ff @(posedge clock) begin
      if (req_fire && req_command == sbnr_pkg::CMD_LOAD) pix_mem[lidx] <= req_pixel_value;
      pix_rd_ff <= pix_mem[pix_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbnr_pkg::TOP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbnr_pkg::TOP_IDLE: begin
            if (req_fire && req_command == sbnr_pkg::CMD_QUERY) state_in = sbnr_pkg::TOP_DIV;
         end
         sbnr_pkg::TOP_DIV: begin
            if (div_done) state_in = sbnr_pkg::TOP_WALK;
         end
         sbnr_pkg::TOP_WALK: begin
            if (walk_sts.done) state_in = sbnr_pkg::TOP_HOLD;
         end
         sbnr_pkg::TOP_HOLD: begin
            if (rsp_load) state_in = sbnr_pkg::TOP_IDLE;
         end
         default: state_in = sbnr_pkg::TOP_IDLE;
      endcase
   end

   assign div_start  = req_fire && (req_command == sbnr_pkg::CMD_QUERY);
   assign walk_start = (state_ff == sbnr_pkg::TOP_DIV) && div_done;

   // Split the query index into column (remainder) and row (quotient).
   sbnr_divider #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (qidx),
      .divisor  (w_eff),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   sbnr_walker #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_RUN   (MAX_RUN)
   ) u_walk (
      .clock      (clock),
      .reset      (reset),
      .start      (walk_start),
      .start_x    (XW'(div_rem)),
      .start_y    (YW'(div_quo)),
      .width      (w_eff),
      .height     (h_eff),
      .need       (need),
      .pix_rd_addr(pix_rd_addr),
      .pix_rd_data(pix_rd_ff),
      .status     (walk_sts)
   );

   // Output register: hold the beat until taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff <= walk_sts.keep ? walk_sts.start_pixel : sbnr_pkg::WHITE;
         rsp_noise_ff <= !walk_sts.keep;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cleaned_pixel = rsp_pixel_ff;
   assign rsp_was_noise     = rsp_noise_ff;
   assign rsp_last_pixel    = rsp_last_ff;

   a_ready_walker_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> walk_sts.ready)
      else $error("request taken while walker busy");

   a_noise_is_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_noise |-> rsp_cleaned_pixel == sbnr_pkg::WHITE)
      else $error("noise pixel not white");

   a_walk_done_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_sts.done |-> state_ff == sbnr_pkg::TOP_WALK)
      else $error("walker finished outside walk phase");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == sbnr_pkg::TOP_DIV)
      else $error("divider finished outside divide phase");

endmodule

/* verif/small_blob_noise_removal_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the small blob noise removal core: directed table, then fixed and random phases.
module small_blob_noise_removal_core_tb;

   localparam int STORE_DEPTH  = sbnr_pkg::DEF_MAX_WIDTH * sbnr_pkg::DEF_MAX_HEIGHT;
   localparam int RUN          = sbnr_pkg::DEF_MAX_RUN;
   // Worst case: sweep of the visit marks, then every query walking 25 pixels
   // with long receiver stalls and long sender gaps, taken about three times over.
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int DX[8] = '{0, -1, -1, -1, 0, 1, 1, 1};
   localparam int DY[8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

   typedef struct {
      logic [7:0] pixel;
      logic       noise;
      logic       last;
   } clean_px_type;

   typedef struct {
      logic         cmd;
      logic [7:0]   pix;
      logic         typed;
      clean_px_type want;
   } stim_row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_command;
   logic [7:0]                       req_pixel_value;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic [7:0]                       rsp_cleaned_pixel;
   logic                             rsp_was_noise;
   logic                             rsp_last_pixel;
   logic                             csr_write_enable;
   logic [sbnr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sbnr_pkg::CSR_DATA_W-1:0]  csr_write_data;

   // Shadow copy of the block: registers, store, visit bookkeeping, raster indexes.
   logic [8:0] width_reg;
   logic [8:0] height_reg;
   logic [4:0] min_size_reg;
   logic [7:0] pix_store [STORE_DEPTH];
   bit         visit_mark [STORE_DEPTH];
   int         visit_pos [RUN];
   int         stk_x [RUN];
   int         stk_y [RUN];
   int         stk_dir [RUN];
   int         n_visited;
   int         load_ptr;
   int         read_ptr;

   clean_px_type pending_clean_q [$];
   clean_px_type got_px;
   clean_px_type head_px;
   int           n_errors;
   int           n_loads;
   int           n_queries;
   int           n_results;
   int           n_settings;
   int           cycle_count;
   bit           quiet_mode;
   int           stall_left;
   stim_row_type directed_rows [$];

   small_blob_noise_removal_core u_top (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("small_blob_noise_removal_core_tb: done, errors");
         $finish;
      end
   end

   function automatic int eff_width();
      if (width_reg == 0) return 1;
      return (width_reg > sbnr_pkg::DEF_MAX_WIDTH) ? sbnr_pkg::DEF_MAX_WIDTH : int'(width_reg);
   endfunction

   function automatic int eff_height();
      if (height_reg == 0) return 1;
      return (height_reg > sbnr_pkg::DEF_MAX_HEIGHT) ? sbnr_pkg::DEF_MAX_HEIGHT
                                                     : int'(height_reg);
   endfunction

   function automatic void mark_px(input int pos);
      visit_mark[pos] = 1'b1;
      if (n_visited < RUN) visit_pos[n_visited] = pos;
      n_visited++;
   endfunction

   // Depth-first walk over black 8-neighbors; true once the group reaches need.
   function automatic bit blob_reaches_min(input int x0, input int y0, input int w,
                                           input int h, input int need);
      int depth;
      int d;
      int nx;
      int ny;
      int pos;
      if (n_visited >= need) return 1'b1;
      mark_px(y0 * w + x0);
      if (n_visited >= need) return 1'b1;
      stk_x[0] = x0;
      stk_y[0] = y0;
      stk_dir[0] = 0;
      depth = 1;
      while (depth > 0) begin
         if (stk_dir[depth-1] >= 8) begin
            depth--;
            continue;
         end
         d = stk_dir[depth-1];
         stk_dir[depth-1]++;
         nx = stk_x[depth-1] + DX[d];
         ny = stk_y[depth-1] + DY[d];
         if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
         pos = ny * w + nx;
         if (pix_store[pos] != 8'd0 || visit_mark[pos]) continue;
         mark_px(pos);
         if (n_visited >= need) return 1'b1;
         if (depth < RUN) begin
            stk_x[depth] = nx;
            stk_y[depth] = ny;
            stk_dir[depth] = 0;
            depth++;
         end
      end
      return 1'b0;
   endfunction

   // Advance the shadow state by one beat; returns whether a result follows.
   function automatic bit predict_clean(input logic cmd, input logic [7:0] pix,
                                        output clean_px_type r);
      int w;
      int h;
      int total;
      int need;
      int lim;
      bit keep;
      w = eff_width();
      h = eff_height();
      total = w * h;
      need = (min_size_reg > RUN) ? RUN : int'(min_size_reg);
      r = '{8'd0, 1'b0, 1'b0};
      if (cmd == sbnr_pkg::CMD_LOAD) begin
         if (load_ptr >= total) load_ptr = 0;
         pix_store[load_ptr] = pix;
         load_ptr++;
         if (load_ptr >= total) load_ptr = 0;
         return 1'b0;
      end
      if (read_ptr >= total) read_ptr = 0;
      n_visited = 0;
      keep = blob_reaches_min(read_ptr % w, read_ptr / w, w, h, need);
      lim = (n_visited > RUN) ? RUN : n_visited;
      for (int k = 0; k < lim; k++) visit_mark[visit_pos[k]] = 1'b0;
      n_visited = 0;
      r.pixel = keep ? pix_store[read_ptr] : sbnr_pkg::WHITE;
      r.noise = !keep;
      r.last  = (read_ptr == total - 1);
      read_ptr++;
      if (read_ptr >= total) read_ptr = 0;
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Hold the beat until accepted, then record the result it will cause.
   task automatic send_beat(input logic cmd, input logic [7:0] pix, input logic typed,
                            input clean_px_type want);
      int gap;
      clean_px_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      if (predict_clean(cmd, pix, r)) pending_clean_q.push_back(typed ? want : r);
      if (cmd == sbnr_pkg::CMD_QUERY) n_queries++;
      else n_loads++;
   endtask

   // Drop valid and wait until every expected result has come.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_clean_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input sbnr_pkg::csr_index_type idx, input logic [8:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         sbnr_pkg::CSR_IMAGE_WIDTH:  width_reg    = data;
         sbnr_pkg::CSR_IMAGE_HEIGHT: height_reg   = data;
         sbnr_pkg::CSR_MIN_SIZE:     min_size_reg = data[4:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [8:0] w, input logic [8:0] h, input logic [4:0] m);
      write_reg(sbnr_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(sbnr_pkg::CSR_IMAGE_HEIGHT, h);
      write_reg(sbnr_pkg::CSR_MIN_SIZE, {4'd0, m});
      n_settings++;
   endtask

   // One setting: fill the whole image first so no walk reads an unwritten pixel,
   // then mostly queries with a few reloads mixed in.
   task automatic run_phase(input logic [8:0] w, input logic [8:0] h, input logic [4:0] m,
                            input int n_mixed, input int black_pct, input bit pause_mid);
      int total;
      clean_px_type none;
      logic [7:0] pix;
      none = '{8'd0, 1'b0, 1'b0};
      drain();
      set_geometry(w, h, m);
      total = eff_width() * eff_height();
      for (int i = 0; i < total; i++) begin
         pix = ($urandom_range(0, 99) < black_pct) ? 8'd0 : 8'($urandom_range(0, 255));
         send_beat(sbnr_pkg::CMD_LOAD, pix, 1'b0, none);
      end
      for (int i = 0; i < n_mixed; i++) begin
         if (pause_mid && i == n_mixed / 2) drain();
         pix = ($urandom_range(0, 99) < black_pct) ? 8'd0 : 8'($urandom_range(0, 255));
         send_beat(($urandom_range(0, 99) < 75) ? sbnr_pkg::CMD_QUERY : sbnr_pkg::CMD_LOAD,
                   pix, 1'b0, none);
      end
   endtask

   // Receiver: random stalls, mostly short, a few long, none in quiet stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet_mode && $urandom_range(0, 99) < 30)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 3);
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_px = '{rsp_cleaned_pixel, rsp_was_noise, rsp_last_pixel};
         n_results++;
         if (pending_clean_q.size() == 0) begin
            $error("result beat with nothing expected: cleaned_pixel %0d", got_px.pixel);
            n_errors++;
         end else begin
            head_px = pending_clean_q.pop_front();
            if (got_px.pixel !== head_px.pixel) begin
               $error("cleaned_pixel: expected %0d, got %0d", head_px.pixel, got_px.pixel);
               n_errors++;
            end
            if (got_px.noise !== head_px.noise) begin
               $error("was_noise: expected %0d, got %0d", head_px.noise, got_px.noise);
               n_errors++;
            end
            if (got_px.last !== head_px.last) begin
               $error("last_pixel: expected %0d, got %0d", head_px.last, got_px.last);
               n_errors++;
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_command      = sbnr_pkg::CMD_LOAD;
      req_pixel_value  = 8'd0;
      csr_write_enable = 1'b0;
      csr_index        = sbnr_pkg::CSR_IMAGE_WIDTH;
      csr_write_data   = '0;
      width_reg        = 9'd200;
      height_reg       = 9'd200;
      min_size_reg     = 5'd8;
      n_visited        = 0;
      load_ptr         = 0;
      read_ptr         = 0;
      n_errors         = 0;
      n_loads          = 0;
      n_queries        = 0;
      n_results        = 0;
      n_settings       = 0;
      cycle_count      = 0;
      quiet_mode       = 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         pix_store[i]  = 8'd0;
         visit_mark[i] = 1'b0;
      end

      // 3x3 image, keep groups of 2:
      //   0   255 255
      //   255 128 1
      //   255 255 0
      // Both black corners are isolated; the nonzero centre starts a walk of its own.
      directed_rows = '{
         '{sbnr_pkg::CMD_LOAD,  8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd255, 1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd255, 1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd255, 1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd128, 1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd1,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd255, 1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd255, 1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_LOAD,  8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b1, '{sbnr_pkg::WHITE, 1'b1, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd255, 1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b0, '{8'd0, 1'b0, 1'b0}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b1, '{sbnr_pkg::WHITE, 1'b1, 1'b1}},
         '{sbnr_pkg::CMD_QUERY, 8'd0,   1'b1, '{sbnr_pkg::WHITE, 1'b1, 1'b0}}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // Registers are taken during the post-reset clearing sweep.
      set_geometry(9'd3, 9'd3, 5'd2);
      foreach (directed_rows[i])
         send_beat(directed_rows[i].cmd, directed_rows[i].pix, directed_rows[i].typed,
                   directed_rows[i].want);

      // Extremes: saturated width with a single row, zero width with saturated height.
      run_phase(9'd511, 9'd1, 5'd31, 40, 70, 1'b0);
      run_phase(9'd0, 9'd511, 5'd0, 40, 70, 1'b0);
      run_phase(9'd16, 9'd16, 5'd25, 60, 80, 1'b1);
      run_phase(9'd1, 9'd1, 5'd1, 20, 50, 1'b0);

      // Random small images until the item budget is spent.
      while (n_loads + n_queries < 1700) begin
         quiet_mode = ($urandom_range(0, 4) == 0);
         run_phase(9'($urandom_range(1, 12)), 9'($urandom_range(1, 12)),
                   ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 10)),
                   $urandom_range(30, 80), $urandom_range(40, 90), 1'b0);
      end
      quiet_mode = 1'b0;

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d load beats and %0d query beats (%0d results) over %0d settings",
               n_loads, n_queries, n_results, n_settings);
      if (n_errors == 0 && pending_clean_q.size() == 0)
         $display("small_blob_noise_removal_core_tb: done, clean");
      else
         $display("small_blob_noise_removal_core_tb: done, errors");
      $finish;
   end

endmodule
